[src/assert_macros.svh]
// Assertion macros used by the dispatcher top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// expr must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
		else $error("assertion failed");
// ante implies cons in the same cycle
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed");
// ante implies cons in the next cycle
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, expr)
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[src/pwqd_pkg.sv]
// Shared types and constants of the per-worker queue dispatcher.
`default_nettype none
package pwqd_pkg;

	localparam int QUEUE_DEPTH_LOG2_DEF = 8;
	localparam int MAX_WORKERS_DEF      = 8;

	localparam int SEL_W      = 3;
	localparam int LEN_W      = 9;
	localparam int WORD_W     = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;

	localparam logic [CFG_IDX_W-1:0] REG_SCHED_MODE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_WORKERS = 2'd1;

	localparam logic [CFG_DATA_W-1:0] ACTIVE_WORKERS_RST = 4'd8;

	localparam logic CMD_ADD  = 1'b0;
	localparam logic CMD_TAKE = 1'b1;

	typedef enum logic [1:0] {
		ST_QUEUED = 2'd0,
		ST_FULL   = 2'd1,
		ST_TAKEN  = 2'd2,
		ST_EMPTY  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RR,
		S_SCAN,
		S_ACCESS,
		S_OUT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic rr_step;
		logic scan_step;
		logic access;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic pick_shortest;
		logic rem_ge_n;
		logic scan_last;
	} stat_t;

endpackage
`default_nettype wire

[src/per_worker_queue_dispatcher.sv]
// Top level of the per-worker job queue dispatcher.
//
//  channel   signals                                        handshake
//  --------  ---------------------------------------------  ------------------------
//  item in   cmd, worker_sel, task_handle, task_arg         taken on start && !busy
//  result    status, worker_id, job_handle, job_arg,        one cycle, marked by done
//            queue_len, wake_worker, worker_drained,
//            all_empty
//  config    cfg_we, cfg_idx, cfg_wdata                     written on cfg_we
//
// Item sequence: a take goes from idle to access and result; an add by round robin
// first runs the pointer modulo, with a subtract step whenever the pointer wraps to
// worker 0 and more steps after active_workers shrank below the pointer; an add by
// least load first scans the length of each active worker in turn.
// One item is in flight at a time; busy stays high until the result cycle ends.
// Reset clears counters and config; the job store is not cleared, since a slot
// is read only after it was written. The receiver cannot stall the result.
`default_nettype none
`include "assert_macros.svh"
module per_worker_queue_dispatcher #(
	parameter int QUEUE_DEPTH_LOG2 = pwqd_pkg::QUEUE_DEPTH_LOG2_DEF,
	parameter int MAX_WORKERS      = pwqd_pkg::MAX_WORKERS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// item in
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic                              cmd,
	input  wire logic [pwqd_pkg::SEL_W-1:0]        worker_sel,
	input  wire logic [pwqd_pkg::WORD_W-1:0]       task_handle,
	input  wire logic [pwqd_pkg::WORD_W-1:0]       task_arg,
	// result
	output logic                                   done,
	output logic      [1:0]                        status,
	output logic      [pwqd_pkg::SEL_W-1:0]        worker_id,
	output logic      [pwqd_pkg::WORD_W-1:0]       job_handle,
	output logic      [pwqd_pkg::WORD_W-1:0]       job_arg,
	output logic      [pwqd_pkg::LEN_W-1:0]        queue_len,
	output logic                                   wake_worker,
	output logic                                   worker_drained,
	output logic                                   all_empty,
	// config
	input  wire logic                              cfg_we,
	input  wire logic [pwqd_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  wire logic [pwqd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

	pwqd_pkg::cmd_t  ctl;
	pwqd_pkg::stat_t stat;

	// sequencing: idle -> pick (rr / scan, adds only) -> access -> result
	pwqd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.stat   (stat),
		.ctl    (ctl),
		.busy   (busy),
		.done   (done)
	);

	// counters, pickers, job store, result registers
	pwqd_dp #(
		.QUEUE_DEPTH_LOG2 (QUEUE_DEPTH_LOG2),
		.MAX_WORKERS      (MAX_WORKERS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.stat           (stat),
		.cfg_we         (cfg_we),
		.cfg_idx        (cfg_idx),
		.cfg_wdata      (cfg_wdata),
		.cmd            (cmd),
		.worker_sel     (worker_sel),
		.task_handle    (task_handle),
		.task_arg       (task_arg),
		.status         (status),
		.worker_id      (worker_id),
		.job_handle     (job_handle),
		.job_arg        (job_arg),
		.queue_len      (queue_len),
		.wake_worker    (wake_worker),
		.worker_drained (worker_drained),
		.all_empty      (all_empty)
	);

	// result cycle lies inside the busy window
	`ASSERT_IMPL(a_done_busy, clk, arst_n, done, busy)
	// an accepted item makes the block busy
	`ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy)
	// one result per item, never two in a row
	`ASSERT_NEXT(a_done_single, clk, arst_n, done, !done)
	// empty take reports a drained queue of length zero
	`ASSERT_IMPL(a_empty_take, clk, arst_n, done && status == pwqd_pkg::ST_EMPTY, worker_drained && queue_len == '0)
	// wake only on a queued add that made the length one
	`ASSERT_IMPL(a_wake, clk, arst_n, done && wake_worker, status == pwqd_pkg::ST_QUEUED && queue_len == 9'd1)

endmodule
`default_nettype wire

[src/pwqd_ram.sv]
// Generic single-port RAM with registered read.
`default_nettype none
module pwqd_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 2048
) (
	input  wire logic                                     clk,
	input  wire logic                                     we,
	input  wire logic                                     re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
	input  wire logic [WIDTH-1:0]                         wdata,
	output logic      [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule
`default_nettype wire

[src/pwqd_dp.sv]
// Datapath: config registers, queue counters, pickers, job store and result registers.
`default_nettype none
module pwqd_dp #(
	parameter int QUEUE_DEPTH_LOG2 = pwqd_pkg::QUEUE_DEPTH_LOG2_DEF,
	parameter int MAX_WORKERS      = pwqd_pkg::MAX_WORKERS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire pwqd_pkg::cmd_t                    ctl,
	output pwqd_pkg::stat_t                        stat,
	input  wire logic                              cfg_we,
	input  wire logic [pwqd_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  wire logic [pwqd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  wire logic                              cmd,
	input  wire logic [pwqd_pkg::SEL_W-1:0]        worker_sel,
	input  wire logic [pwqd_pkg::WORD_W-1:0]       task_handle,
	input  wire logic [pwqd_pkg::WORD_W-1:0]       task_arg,
	output logic      [1:0]                        status,
	output logic      [pwqd_pkg::SEL_W-1:0]        worker_id,
	output logic      [pwqd_pkg::WORD_W-1:0]       job_handle,
	output logic      [pwqd_pkg::WORD_W-1:0]       job_arg,
	output logic      [pwqd_pkg::LEN_W-1:0]        queue_len,
	output logic                                   wake_worker,
	output logic                                   worker_drained,
	output logic                                   all_empty
);

	localparam int WIDX_W  = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
	localparam int NW      = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS + 1) : 1;
	localparam int CW      = WIDX_W + 1;
	localparam int CNT_W   = QUEUE_DEPTH_LOG2 + 1;
	localparam int RAM_D   = MAX_WORKERS << QUEUE_DEPTH_LOG2;
	localparam int RAM_AW  = (RAM_D > 1) ? $clog2(RAM_D) : 1;
	localparam int JOB_W   = 2 * pwqd_pkg::WORD_W;
	localparam logic [CNT_W-1:0] LEN_FULL = {1'b1, {QUEUE_DEPTH_LOG2{1'b0}}};

	// config
	logic                              mode_q;
	logic [pwqd_pkg::CFG_DATA_W-1:0]   aw_q;

	// queue state
	logic [CNT_W-1:0] wcnt_q [MAX_WORKERS];
	logic [CNT_W-1:0] rcnt_q [MAX_WORKERS];
	logic [WIDX_W-1:0] rr_q;
	logic              rr_started_q;

	// item state
	logic                            cmd_q;
	logic [pwqd_pkg::SEL_W-1:0]      sel_q;
	logic [pwqd_pkg::WORD_W-1:0]     handle_q;
	logic [pwqd_pkg::WORD_W-1:0]     arg_q;
	logic [WIDX_W-1:0]               wid_q;
	logic [WIDX_W-1:0]               scan_q;
	logic [CW-1:0]                   rem_q;
	logic [CNT_W-1:0]                best_len_q;

	// result
	pwqd_pkg::status_t               res_status_q;
	logic [pwqd_pkg::SEL_W-1:0]      res_wid_q;
	logic [pwqd_pkg::LEN_W-1:0]      res_len_q;
	logic                            res_wake_q;
	logic                            res_drained_q;

	logic [NW-1:0]      n_act;
	logic [WIDX_W-1:0]  rd_idx;
	logic [CNT_W-1:0]   len_rd;
	logic               sel_ok;
	logic               ram_we;
	logic               ram_re;
	logic [RAM_AW-1:0]  ram_addr;
	logic [JOB_W-1:0]   ram_rdata;
	logic [QUEUE_DEPTH_LOG2-1:0] slot;

	// clamp active count to 1..MAX_WORKERS
	always_comb begin
		if (aw_q == '0) begin
			n_act = NW'(1);
		end else if (int'(aw_q) > MAX_WORKERS) begin
			n_act = NW'(MAX_WORKERS);
		end else begin
			n_act = NW'(aw_q);
		end
	end

	assign rd_idx = ctl.scan_step ? scan_q : wid_q;
	assign len_rd = wcnt_q[rd_idx] - rcnt_q[rd_idx];
	assign sel_ok = int'(sel_q) < MAX_WORKERS;

	assign stat.pick_shortest = mode_q;
	assign stat.rem_ge_n      = rem_q >= CW'(n_act);
	assign stat.scan_last     = scan_q == WIDX_W'(n_act - NW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			aw_q   <= pwqd_pkg::ACTIVE_WORKERS_RST;
		end else if (cfg_we) begin
			if (cfg_idx == pwqd_pkg::REG_SCHED_MODE) begin
				mode_q <= cfg_wdata[0];
			end else if (cfg_idx == pwqd_pkg::REG_ACTIVE_WORKERS) begin
				aw_q <= cfg_wdata;
			end
		end
	end

	// payload of the item in flight
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q    <= cmd;
			sel_q    <= worker_sel;
			handle_q <= task_handle;
			arg_q    <= task_arg;
		end
	end

	// worker pick: round robin by repeated subtraction, least load by scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rr_q         <= WIDX_W'(MAX_WORKERS - 1);
			rr_started_q <= 1'b0;
			wid_q        <= '0;
			scan_q       <= '0;
			rem_q        <= '0;
			best_len_q   <= '0;
		end else if (ctl.load) begin
			wid_q  <= WIDX_W'(worker_sel);
			scan_q <= '0;
			rem_q  <= rr_started_q ? (CW'(rr_q) + CW'(1)) : '0;
		end else if (ctl.rr_step) begin
			if (stat.rem_ge_n) begin
				rem_q <= rem_q - CW'(n_act);
			end else begin
				wid_q        <= WIDX_W'(rem_q);
				rr_q         <= WIDX_W'(rem_q);
				rr_started_q <= 1'b1;
			end
		end else if (ctl.scan_step) begin
			if (scan_q == '0 || len_rd < best_len_q) begin
				best_len_q <= len_rd;
				wid_q      <= scan_q;
			end
			scan_q <= scan_q + WIDX_W'(1);
		end
	end

	// access: update counters, fill result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_WORKERS; i++) begin
				wcnt_q[i] <= '0;
				rcnt_q[i] <= '0;
			end
		end else if (ctl.access) begin
			if (cmd_q == pwqd_pkg::CMD_ADD) begin
				if (len_rd != LEN_FULL) begin
					wcnt_q[wid_q] <= wcnt_q[wid_q] + CNT_W'(1);
				end
			end else if (sel_ok && len_rd != '0) begin
				rcnt_q[wid_q] <= rcnt_q[wid_q] + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.access) begin
			res_wake_q    <= 1'b0;
			res_drained_q <= 1'b0;
			if (cmd_q == pwqd_pkg::CMD_ADD) begin
				res_wid_q <= pwqd_pkg::SEL_W'(wid_q);
				if (len_rd != LEN_FULL) begin
					res_status_q <= pwqd_pkg::ST_QUEUED;
					res_len_q    <= pwqd_pkg::LEN_W'(len_rd + CNT_W'(1));
					res_wake_q   <= len_rd == '0;
				end else begin
					res_status_q <= pwqd_pkg::ST_FULL;
					res_len_q    <= pwqd_pkg::LEN_W'(len_rd);
				end
			end else begin
				res_wid_q <= sel_q;
				if (sel_ok && len_rd != '0) begin
					res_status_q  <= pwqd_pkg::ST_TAKEN;
					res_len_q     <= pwqd_pkg::LEN_W'(len_rd - CNT_W'(1));
					res_drained_q <= len_rd == CNT_W'(1);
				end else begin
					res_status_q  <= pwqd_pkg::ST_EMPTY;
					res_len_q     <= '0;
					res_drained_q <= 1'b1;
				end
			end
		end
	end

	// job store: write slot on add, read slot on take
	assign slot     = (cmd_q == pwqd_pkg::CMD_ADD) ? wcnt_q[wid_q][QUEUE_DEPTH_LOG2-1:0]
		: rcnt_q[wid_q][QUEUE_DEPTH_LOG2-1:0];
	assign ram_addr = RAM_AW'({wid_q, slot});
	assign ram_we   = ctl.access && cmd_q == pwqd_pkg::CMD_ADD && len_rd != LEN_FULL;
	assign ram_re   = ctl.access && cmd_q == pwqd_pkg::CMD_TAKE && sel_ok && len_rd != '0;

	pwqd_ram #(
		.WIDTH (JOB_W),
		.DEPTH (RAM_D)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata ({handle_q, arg_q}),
		.rdata (ram_rdata)
	);

	// all active queues empty, from counters after the update
	always_comb begin
		all_empty = 1'b1;
		for (int i = 0; i < MAX_WORKERS; i++) begin
			if (i < int'(n_act) && wcnt_q[i] != rcnt_q[i]) begin
				all_empty = 1'b0;
			end
		end
	end

	assign status         = res_status_q;
	assign worker_id      = res_wid_q;
	assign job_handle     = (res_status_q == pwqd_pkg::ST_TAKEN) ?
		ram_rdata[JOB_W-1:pwqd_pkg::WORD_W] : '0;
	assign job_arg        = (res_status_q == pwqd_pkg::ST_TAKEN) ?
		ram_rdata[pwqd_pkg::WORD_W-1:0] : '0;
	assign queue_len      = res_len_q;
	assign wake_worker    = res_wake_q;
	assign worker_drained = res_drained_q;

endmodule
`default_nettype wire

[src/pwqd_ctrl.sv]
// Controller state machine sequencing pick, access and result.
`default_nettype none
module pwqd_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic              cmd,
	input  wire pwqd_pkg::stat_t   stat,
	output pwqd_pkg::cmd_t         ctl,
	output logic                   busy,
	output logic                   done
);

	pwqd_pkg::state_t state_q;
	pwqd_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pwqd_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			pwqd_pkg::S_IDLE: begin
				if (start) begin
					if (cmd == pwqd_pkg::CMD_TAKE) begin
						state_nxt = pwqd_pkg::S_ACCESS;
					end else if (stat.pick_shortest) begin
						state_nxt = pwqd_pkg::S_SCAN;
					end else begin
						state_nxt = pwqd_pkg::S_RR;
					end
				end
			end
			pwqd_pkg::S_RR: begin
				if (!stat.rem_ge_n) begin
					state_nxt = pwqd_pkg::S_ACCESS;
				end
			end
			pwqd_pkg::S_SCAN: begin
				if (stat.scan_last) begin
					state_nxt = pwqd_pkg::S_ACCESS;
				end
			end
			pwqd_pkg::S_ACCESS: state_nxt = pwqd_pkg::S_OUT;
			pwqd_pkg::S_OUT:    state_nxt = pwqd_pkg::S_IDLE;
			default:            state_nxt = pwqd_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		ctl  = '0;
		busy = 1'b1;
		done = 1'b0;
		case (state_q)
			pwqd_pkg::S_IDLE: begin
				busy     = 1'b0;
				ctl.load = start;
			end
			pwqd_pkg::S_RR:     ctl.rr_step   = 1'b1;
			pwqd_pkg::S_SCAN:   ctl.scan_step = 1'b1;
			pwqd_pkg::S_ACCESS: ctl.access    = 1'b1;
			pwqd_pkg::S_OUT:    done          = 1'b1;
			default:            busy          = 1'b1;
		endcase
	end

endmodule
`default_nettype wire
